@@ rtl/sdp_pkg.sv @@
package sdp_pkg;

   // Input item: source position (Q8.8) and mono sample
   typedef struct packed {
      logic signed [15:0] source_x;
      logic signed [15:0] source_y;
      logic signed [15:0] source_z;
      logic signed [15:0] sample;
   } req_type;

   // Result item: stereo pair and the gains behind it
   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [15:0]        left_gain;
      logic [15:0]        right_gain;
      logic [15:0]        distance_gain;
   } rsp_type;

   // Data that rides along the square root and divider stages
   typedef struct packed {
      logic signed [15:0] sample;
      logic               neg;
      logic               behind;
      logic [33:0]        mag;
   } side_type;

   // Data that rides along the gain and output stages
   typedef struct packed {
      logic signed [15:0] sample;
      logic               behind;
      logic [15:0]        dg;
   } post_type;

   // Register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTENER_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTENER_RIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTENER_FORWARD  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] POSITION_RESET = 48'd0;
   localparam logic [CSR_DATA_W-1:0] RIGHT_RESET    = 48'd16384;
   localparam logic [CSR_DATA_W-1:0] FORWARD_RESET  = 48'd211106232532992;

   // Arithmetic constants
   localparam logic [24:0] DIST_FLOOR = 25'd6554;
   localparam logic [15:0] BACK_GAIN  = 16'd22938;
   localparam logic [14:0] ONE_Q14    = 15'd16384;
   localparam logic [15:0] ONE_Q15    = 16'd32768;

   // Odd degree-9 quarter-sine polynomial, Q1.30
   localparam logic signed [32:0] SC9 = 33'sd172272;
   localparam logic signed [32:0] HORNER_COEF [0:3] = '{
      -33'sd5026995, 33'sd85569306, -33'sd693598669, 33'sd1686629713
   };

   // Pipeline shape
   localparam int SQ_BITS    = 25;
   localparam int DIV_BITS   = 15;
   localparam int NUM_STAGES = 3 + SQ_BITS + 1 + DIV_BITS + 1 + 6 + 1 + 2;

endpackage

@@ rtl/stereo_distance_panner.sv @@
// Channel  Ports                              Direction  Item
// req      req_valid/req_ready/req_data       in         source x,y,z + mono sample
// rsp      rsp_valid/rsp_ready/rsp_data       out        stereo pair + three gains
// csr      csr_wr_en/csr_index/csr_wdata      in         listener pose registers
//
// One item per cycle while the skid register is empty; the square root has 25
// one-bit stages and the dividers have 15 stages.
// Reset clears all valid bits and the skid stage and loads the listener registers with their reset pose.
// A stalled result parks in a skid register; the pipeline freezes only then.
module stereo_distance_panner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sdp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sdp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [sdp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sdp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sdp_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [CSR_DATA_W-1:0] lpos_ff, lright_ff, lfwd_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   logic                  adv;
   logic                  rsp_valid_ff, skid_full_ff;
   rsp_type               out_ff, skid_ff, fin_data;

   // Stage A / B / C registers
   logic signed [16:0] rel_x_ff, rel_y_ff, rel_z_ff;
   logic signed [15:0] smp_a_ff, smp_b_ff;
   logic signed [33:0] sqx_ff, sqy_ff, sqz_ff;
   logic signed [32:0] drx_ff, dry_ff, drz_ff, dfx_ff, dfy_ff, dfz_ff;
   logic signed [34:0] sum_sq, dotr, dotf, dotr_abs;

   // Square root stages
   logic [51:0]   sq_rem_ff  [0:SQ_BITS];
   logic [24:0]   sq_root_ff [0:SQ_BITS];
   side_type      sq_side_ff [0:SQ_BITS];

   // Divider stages
   logic [24:0]   dist_q16;
   logic [25:0]   den;
   logic [42:0]   num_pan;
   logic [33:0]   dg_rem_ff  [0:DIV_BITS];
   logic [25:0]   dg_den_ff  [0:DIV_BITS];
   logic [14:0]   dg_q_ff    [0:DIV_BITS];
   logic [42:0]   pn_rem_ff  [0:DIV_BITS];
   logic [24:0]   pn_dist_ff [0:DIV_BITS];
   logic [14:0]   pn_q_ff    [0:DIV_BITS];
   logic          pn_sat_ff  [0:DIV_BITS];
   side_type      dv_side_ff [0:DIV_BITS];

   // Pan and gain stages
   logic [14:0]   qc;
   logic [15:0]   u;
   logic [15:0]   x_e_ff [0:1];
   post_type      pst_ff [0:8];
   logic signed [15:0] lane_smp_ff  [0:1];
   logic [15:0]        lane_gain_ff [0:1];
   logic [15:0]        fin_dg_ff;

   assign adv       = !skid_full_ff;
   assign req_ready = adv;

   // Write listener registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lpos_ff   <= POSITION_RESET;
         lright_ff <= RIGHT_RESET;
         lfwd_ff   <= FORWARD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LISTENER_POSITION: lpos_ff   <= csr_wdata;
            CSR_LISTENER_RIGHT:    lright_ff <= csr_wdata;
            CSR_LISTENER_FORWARD:  lfwd_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // Stages A and B: relative position, squares and dot products
   always_ff @(posedge clock) begin
      if (adv) begin
         rel_x_ff <= $signed({req_data.source_x[15], req_data.source_x})
                   - $signed({lpos_ff[15], lpos_ff[15:0]});
         rel_y_ff <= $signed({req_data.source_y[15], req_data.source_y})
                   - $signed({lpos_ff[31], lpos_ff[31:16]});
         rel_z_ff <= $signed({req_data.source_z[15], req_data.source_z})
                   - $signed({lpos_ff[47], lpos_ff[47:32]});
         smp_a_ff <= req_data.sample;
         sqx_ff   <= rel_x_ff * rel_x_ff;
         sqy_ff   <= rel_y_ff * rel_y_ff;
         sqz_ff   <= rel_z_ff * rel_z_ff;
         drx_ff   <= rel_x_ff * $signed(lright_ff[15:0]);
         dry_ff   <= rel_y_ff * $signed(lright_ff[31:16]);
         drz_ff   <= rel_z_ff * $signed(lright_ff[47:32]);
         dfx_ff   <= rel_x_ff * $signed(lfwd_ff[15:0]);
         dfy_ff   <= rel_y_ff * $signed(lfwd_ff[31:16]);
         dfz_ff   <= rel_z_ff * $signed(lfwd_ff[47:32]);
         smp_b_ff <= smp_a_ff;
      end
   end

   // Stage C: sum into the square root's first stage
   always_comb begin
      sum_sq   = 35'(sqx_ff) + 35'(sqy_ff) + 35'(sqz_ff);
      dotr     = 35'(drx_ff) + 35'(dry_ff) + 35'(drz_ff);
      dotf     = 35'(dfx_ff) + 35'(dfy_ff) + 35'(dfz_ff);
      dotr_abs = dotr[34] ? -dotr : dotr;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]         <= {2'b0, sum_sq[33:0], 16'b0};
         sq_root_ff[0]        <= '0;
         sq_side_ff[0].sample <= smp_b_ff;
         sq_side_ff[0].neg    <= dotr[34];
         sq_side_ff[0].behind <= dotf[34];
         sq_side_ff[0].mag    <= dotr_abs[33:0];
      end
   end

   // Square root: one result bit per stage
   for (genvar i = 0; i < SQ_BITS; i++) begin : g_sqrt
      localparam int K = SQ_BITS - 1 - i;
      logic [51:0] trial;
      assign trial = (52'(sq_root_ff[i]) << (K + 1)) + (52'd1 << (2 * K));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (sq_rem_ff[i] >= trial) begin
               sq_rem_ff[i+1]  <= sq_rem_ff[i] - trial;
               sq_root_ff[i+1] <= sq_root_ff[i] | (25'd1 << K);
            end else begin
               sq_rem_ff[i+1]  <= sq_rem_ff[i];
               sq_root_ff[i+1] <= sq_root_ff[i];
            end
            sq_side_ff[i+1] <= sq_side_ff[i];
         end
      end
   end

   // Stage D: floor distance, set up both divisions
   always_comb begin
      dist_q16 = (sq_root_ff[SQ_BITS] < DIST_FLOOR) ? DIST_FLOOR : sq_root_ff[SQ_BITS];
      den      = 26'(dist_q16) + 26'd131072;
      num_pan  = {1'b0, sq_side_ff[SQ_BITS].mag, 8'b0} + 43'(dist_q16 >> 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dg_rem_ff[0]  <= 34'h1_0000_0000 + 34'(den >> 1);
         dg_den_ff[0]  <= den;
         dg_q_ff[0]    <= '0;
         pn_rem_ff[0]  <= num_pan;
         pn_dist_ff[0] <= dist_q16;
         pn_q_ff[0]    <= '0;
         pn_sat_ff[0]  <= num_pan >= 43'({dist_q16, 15'b0});
         dv_side_ff[0] <= sq_side_ff[SQ_BITS];
      end
   end

   // Restoring dividers: one quotient bit per stage
   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      localparam int K = DIV_BITS - 1 - j;
      logic [40:0] dg_trial, dg_diff;
      logic [42:0] pn_trial, pn_diff;
      assign dg_trial = 41'(dg_den_ff[j]) << K;
      assign dg_diff  = 41'(dg_rem_ff[j]) - dg_trial;
      assign pn_trial = 43'(pn_dist_ff[j]) << K;
      assign pn_diff  = pn_rem_ff[j] - pn_trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (41'(dg_rem_ff[j]) >= dg_trial) begin
               dg_rem_ff[j+1] <= dg_diff[33:0];
               dg_q_ff[j+1]   <= dg_q_ff[j] | (15'd1 << K);
            end else begin
               dg_rem_ff[j+1] <= dg_rem_ff[j];
               dg_q_ff[j+1]   <= dg_q_ff[j];
            end
            if (pn_rem_ff[j] >= pn_trial) begin
               pn_rem_ff[j+1] <= pn_diff;
               pn_q_ff[j+1]   <= pn_q_ff[j] | (15'd1 << K);
            end else begin
               pn_rem_ff[j+1] <= pn_rem_ff[j];
               pn_q_ff[j+1]   <= pn_q_ff[j];
            end
            dg_den_ff[j+1]  <= dg_den_ff[j];
            pn_dist_ff[j+1] <= pn_dist_ff[j];
            pn_sat_ff[j+1]  <= pn_sat_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   // Stage E: clamp pan, map to the sine arguments
   always_comb begin
      qc = (pn_sat_ff[DIV_BITS] || pn_q_ff[DIV_BITS] > ONE_Q14) ? ONE_Q14
                                                               : pn_q_ff[DIV_BITS];
      u  = dv_side_ff[DIV_BITS].neg ? 16'(ONE_Q14) - 16'(qc) : 16'(ONE_Q14) + 16'(qc);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_e_ff[0]        <= ONE_Q15 - u;
         x_e_ff[1]        <= u;
         pst_ff[0].sample <= dv_side_ff[DIV_BITS].sample;
         pst_ff[0].behind <= dv_side_ff[DIV_BITS].behind;
         pst_ff[0].dg     <= {1'b0, dg_q_ff[DIV_BITS]};
         for (int i = 1; i < 9; i++) begin
            pst_ff[i] <= pst_ff[i-1];
         end
      end
   end

   // Per lane: quarter sine, back attenuation, output scaling (left = 0)
   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [31:0]        xx;
      logic [16:0]        x2_ff  [0:3];
      logic signed [32:0] acc_ff [0:4];
      logic [15:0]        xs_ff  [0:4];
      logic signed [49:0] r_prod, r_rnd, r_sh;
      logic [15:0]        g_ff, bg_ff, gm_ff;
      logic [30:0]        b_prod;
      logic signed [32:0] p_ff;
      logic signed [49:0] o_prod, o_sh;

      // S0: square the argument
      assign xx = 32'(x_e_ff[l]) * 32'(x_e_ff[l]);
      always_ff @(posedge clock) begin
         if (adv) begin
            x2_ff[0]  <= xx[31:15];
            acc_ff[0] <= SC9;
            xs_ff[0]  <= x_e_ff[l];
         end
      end

      // S1..S4: Horner steps
      for (genvar h = 0; h < 4; h++) begin : g_horner
         logic signed [50:0] prod, sh;
         assign prod = 51'(acc_ff[h]) * 51'($signed({1'b0, x2_ff[h]}));
         assign sh   = (prod >>> 15) + 51'(HORNER_COEF[h]);
         always_ff @(posedge clock) begin
            if (adv) begin
               acc_ff[h+1] <= sh[32:0];
               xs_ff[h+1]  <= xs_ff[h];
            end
         end
         if (h < 3) begin : g_carry
            always_ff @(posedge clock) begin
               if (adv) begin
                  x2_ff[h+1] <= x2_ff[h];
               end
            end
         end
      end

      // S5: final multiply, round and clamp to [0, 1]
      assign r_prod = 50'(acc_ff[4]) * 50'($signed({1'b0, xs_ff[4]}));
      assign r_rnd  = r_prod + 50'sd536870912;
      assign r_sh   = r_rnd >>> 30;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (r_sh < 50'sd0) begin
               g_ff <= '0;
            end else if (r_sh > 50'sd32768) begin
               g_ff <= ONE_Q15;
            end else begin
               g_ff <= r_sh[15:0];
            end
         end
      end

      // Scale a source behind the listener by 0.7
      assign b_prod = 31'(g_ff) * 31'(BACK_GAIN) + 31'd16384;
      always_ff @(posedge clock) begin
         if (adv) begin
            bg_ff <= pst_ff[6].behind ? b_prod[30:15] : g_ff;
         end
      end

      // Sample times pan gain
      always_ff @(posedge clock) begin
         if (adv) begin
            p_ff  <= 33'(pst_ff[7].sample) * 33'($signed({1'b0, bg_ff}));
            gm_ff <= bg_ff;
         end
      end

      // Times distance gain, round and saturate
      assign o_prod = 50'(p_ff) * 50'($signed({1'b0, pst_ff[8].dg}));
      assign o_sh   = (o_prod + 50'sd536870912) >>> 30;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (o_sh > 50'sd32767) begin
               lane_smp_ff[l] <= 16'sh7fff;
            end else if (o_sh < -50'sd32768) begin
               lane_smp_ff[l] <= -16'sh8000;
            end else begin
               lane_smp_ff[l] <= o_sh[15:0];
            end
            lane_gain_ff[l] <= gm_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_dg_ff <= pst_ff[8].dg;
      end
   end

   always_comb begin
      fin_data.left_sample   = lane_smp_ff[0];
      fin_data.right_sample  = lane_smp_ff[1];
      fin_data.left_gain     = lane_gain_ff[0];
      fin_data.right_gain    = lane_gain_ff[1];
      fin_data.distance_gain = fin_dg_ff;
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= vld_ff[LAST];
      end else if (vld_ff[LAST]) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         out_ff <= fin_data;
      end else begin
         skid_ff <= fin_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid filled without an output stall");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |=> $stable(vld_ff))
      else $error("pipeline moved while the skid was full");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data.left_gain <= ONE_Q15 && rsp_data.right_gain <= ONE_Q15
                        && rsp_data.distance_gain <= ONE_Q15))
      else $error("gain above unity");
`endif

endmodule

@@ tb/stereo_distance_panner_tb.sv @@
`timescale 1ns / 100ps

module stereo_distance_panner_tb;
   import sdp_pkg::*;

   localparam int LATENCY     = 54;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // listener pose as the predictor sees it
   logic [47:0] pose_position;
   logic [47:0] pose_right;
   logic [47:0] pose_forward;

   rsp_type pending_mix[$];
   int error_count = 0;
   int result_count = 0;
   int item_count = 0;
   int cycle_count = 0;
   int stall_phase = 0;

   stereo_distance_panner DUT (.*);

   always #1 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint signed half_of(logic [47:0] r, int k);
      logic signed [15:0] h;
      h = r[16*k +: 16];
      return longint'(h);
   endfunction

   function automatic longint signed floor_sh(longint signed v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint signed sine_quarter(longint signed x);
      longint signed x2, acc, r;
      x2 = (x * x) >>> 15;
      acc = 172272;
      acc = -5026995 + floor_sh(acc * x2, 15);
      acc = 85569306 + floor_sh(acc * x2, 15);
      acc = -693598669 + floor_sh(acc * x2, 15);
      acc = 1686629713 + floor_sh(acc * x2, 15);
      r = floor_sh(acc * x + (64'sd1 << 29), 30);
      if (r < 0) r = 0;
      if (r > 32768) r = 32768;
      return r;
   endfunction

   function automatic logic [15:0] scale_sample(longint signed s, longint signed g,
                                                longint signed d);
      longint signed v;
      v = floor_sh(s * g * d + (64'sd1 << 29), 30);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic rsp_type mix_predict(req_type it);
      longint signed rel[3];
      longint signed dotr, dotf, pan, u, lg, rg, dg, smp;
      longint unsigned sq, dist_q16, den, mag, q;
      logic [15:0] pos[3];
      rsp_type o;
      pos[0] = it.source_x;
      pos[1] = it.source_y;
      pos[2] = it.source_z;
      dotr = 0;
      dotf = 0;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
         rel[k] = longint'($signed(pos[k])) - half_of(pose_position, k);
         sq += longint'(rel[k] * rel[k]);
         dotr += rel[k] * half_of(pose_right, k);
         dotf += rel[k] * half_of(pose_forward, k);
      end
      smp = longint'(it.sample);
      dist_q16 = int_sqrt(sq << 16);
      if (dist_q16 < 6554) dist_q16 = 6554;
      den = (64'd1 << 17) + dist_q16;
      dg = ((64'd1 << 32) + den / 2) / den;
      mag = dotr < 0 ? -dotr : dotr;
      q = (mag * 256 + dist_q16 / 2) / dist_q16;
      if (q > 16384) q = 16384;
      pan = dotr < 0 ? -longint'(q) : longint'(q);
      u = pan + 16384;
      rg = sine_quarter(u);
      lg = sine_quarter(32768 - u);
      // attenuate sources behind the listener
      if (dotf < 0) begin
         rg = (rg * 22938 + (64'sd1 << 14)) >>> 15;
         lg = (lg * 22938 + (64'sd1 << 14)) >>> 15;
      end
      o.left_sample   = scale_sample(smp, lg, dg);
      o.right_sample  = scale_sample(smp, rg, dg);
      o.left_gain     = lg[15:0];
      o.right_gain    = rg[15:0];
      o.distance_gain = dg[15:0];
      return o;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH result %0d %s: got %h want %h", result_count, what, got, want);
      error_count++;
   endtask

   // receiver stall pattern: long ready runs, bursts of stalls, random phases
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      stall_phase <= stall_phase + 1;
      if (reset) rsp_ready <= 1'b0;
      else if (stall_phase % 400 < 120) rsp_ready <= 1'b1;
      else if (stall_phase % 37 < 9) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_mix.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.left_sample, 16'h0000);
         end else begin
            want = pending_mix.pop_front();
            if (rsp_data.left_sample !== want.left_sample)
               report_mismatch("left_sample", rsp_data.left_sample, want.left_sample);
            if (rsp_data.right_sample !== want.right_sample)
               report_mismatch("right_sample", rsp_data.right_sample, want.right_sample);
            if (rsp_data.left_gain !== want.left_gain)
               report_mismatch("left_gain", rsp_data.left_gain, want.left_gain);
            if (rsp_data.right_gain !== want.right_gain)
               report_mismatch("right_gain", rsp_data.right_gain, want.right_gain);
            if (rsp_data.distance_gain !== want.distance_gain)
               report_mismatch("distance_gain", rsp_data.distance_gain,
                               want.distance_gain);
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   int burst_left = 0;

   // send one item; between bursts, sometimes drop valid for a random gap
   task automatic send_item(req_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      pending_mix.push_back(mix_predict(it));
      item_count++;
   endtask

   task automatic drain_mix();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pose(logic [CSR_IDX_W-1:0] idx, logic [47:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LISTENER_POSITION: pose_position = v;
         CSR_LISTENER_RIGHT:    pose_right = v;
         CSR_LISTENER_FORWARD:  pose_forward = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type make_item(logic [15:0] x, logic [15:0] y,
                                         logic [15:0] z, logic [15:0] s);
      req_type it;
      it.source_x = x;
      it.source_y = y;
      it.source_z = z;
      it.sample   = s;
      return it;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      send_item(make_item(16'h0000, 16'h0000, 16'h0000, 16'h7FFF)); // source at listener
      send_item(make_item(16'h0000, 16'h0000, 16'h0000, 16'h8000));
      send_item(make_item(16'h0100, 16'h0000, 16'h0000, 16'h7FFF)); // hard right, on the front/back boundary
      send_item(make_item(16'hFF00, 16'h0000, 16'h0000, 16'h7FFF)); // hard left
      send_item(make_item(16'h0000, 16'h0000, 16'hFF00, 16'h8000)); // straight ahead
      send_item(make_item(16'h0000, 16'h0000, 16'h0100, 16'h7FFF)); // straight behind
      send_item(make_item(16'h0010, 16'h0000, 16'h0000, 16'h1234)); // inside distance floor
      send_item(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_item(make_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF));
      send_item(make_item(16'h0080, 16'h0080, 16'hFF80, 16'h0001));
      send_item(make_item(16'h0100, 16'h0000, 16'h0100, 16'h0000));
      drain_mix();
   endtask

   task automatic test_pose_extremes();
      // listener far corner, non-unit vectors
      write_pose(CSR_LISTENER_POSITION, 48'h7FFF_8000_7FFF);
      write_pose(CSR_LISTENER_RIGHT, 48'h7FFF_7FFF_7FFF);
      write_pose(CSR_LISTENER_FORWARD, 48'h8000_8000_8000);
      send_item(make_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_item(make_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
      send_item(make_item(16'h0000, 16'h0000, 16'h0000, 16'h4000));
      drain_mix();
      write_pose(CSR_LISTENER_POSITION, 48'hFFFF_FFFF_FFFF);
      write_pose(CSR_LISTENER_RIGHT, 48'h0);
      write_pose(CSR_LISTENER_FORWARD, 48'h0);
      send_item(make_item(16'h0200, 16'h0300, 16'h0400, 16'h7FFF));
      send_item(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF));
      drain_mix();
   endtask

   task automatic test_random_pose(int n);
      logic [47:0] r;
      // pick a random listener pose, sometimes unit axes
      r = {16'($urandom), 32'($urandom)};
      write_pose(CSR_LISTENER_POSITION, ($urandom_range(0, 1) != 0) ? r : 48'h0);
      case ($urandom_range(0, 2))
         0: begin
            write_pose(CSR_LISTENER_RIGHT, 48'h0000_0000_C000);
            write_pose(CSR_LISTENER_FORWARD, 48'h4000_0000_0000);
         end
         1: begin
            write_pose(CSR_LISTENER_RIGHT, 48'h0000_2D41_2D41);
            write_pose(CSR_LISTENER_FORWARD, 48'hC000_0000_0000);
         end
         default: begin
            write_pose(CSR_LISTENER_RIGHT, {16'($urandom), 32'($urandom)});
            write_pose(CSR_LISTENER_FORWARD, {16'($urandom), 32'($urandom)});
         end
      endcase
      for (int k = 0; k < n; k++)
         send_item(make_item(rand_coord(), rand_coord(), rand_coord(), 16'($urandom)));
      drain_mix();
   endtask

   initial begin
      pose_position = POSITION_RESET;
      pose_right    = RIGHT_RESET;
      pose_forward  = FORWARD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pose_extremes();
      for (int p = 0; p < 10; p++) test_random_pose(63);
      write_pose(CSR_LISTENER_POSITION, POSITION_RESET);
      write_pose(CSR_LISTENER_RIGHT, RIGHT_RESET);
      write_pose(CSR_LISTENER_FORWARD, FORWARD_RESET);
      test_random_pose(0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d items over directed, extreme and random listener poses", item_count);
      $display("Checked %0d results", result_count);
      if (error_count == 0 && pending_mix.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sdp_pkg.sv
rtl/stereo_distance_panner.sv
tb/stereo_distance_panner_tb.sv
